@@ hw/rtl/mbtc_pkg.sv @@
// Shared types and constants for the Modbus TCP response checker.
// Beat structs, frame summary, status codes and function codes.
// No dependencies.
package mbtc_pkg;

  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam int HDR_BYTES = 6;
  localparam int MAX_PDU = 253;
  localparam int MAX_FRAME = MAX_PDU + HDR_BYTES;

  localparam logic [31:0] SENTINEL = 32'hBAAD_F00D;

  localparam logic [7:0] EXC_FLAG     = 8'h80;
  localparam logic [7:0] EXC_CODE_MAX = 8'h0F;
  localparam logic [7:0] FC_MAX       = 8'h6F;
  localparam logic [7:0] BITS_BC_MAX  = 8'hF7;
  localparam logic [7:0] REGS_BC_MAX  = 8'hFA;

  localparam logic [7:0] FC_RD_COILS  = 8'h01;
  localparam logic [7:0] FC_RD_DISC   = 8'h02;
  localparam logic [7:0] FC_RD_HOLD   = 8'h03;
  localparam logic [7:0] FC_RD_INPUT  = 8'h04;
  localparam logic [7:0] FC_WR_COIL   = 8'h05;
  localparam logic [7:0] FC_WR_REG    = 8'h06;
  localparam logic [7:0] FC_DIAG      = 8'h08;
  localparam logic [7:0] FC_WR_COILS  = 8'h0F;
  localparam logic [7:0] FC_WR_REGS   = 8'h10;
  localparam logic [7:0] FC_MEI       = 8'h2B;

  localparam logic [4:0] ST_OK           = 5'd0;
  localparam logic [4:0] ST_SHORT        = 5'd1;
  localparam logic [4:0] ST_PROTO        = 5'd2;
  localparam logic [4:0] ST_LEN_MISMATCH = 5'd3;
  localparam logic [4:0] ST_TOO_LONG     = 5'd4;
  localparam logic [4:0] ST_EXC_CODE     = 5'd5;
  localparam logic [4:0] ST_EXCEPTION    = 5'd6;
  localparam logic [4:0] ST_FC_RANGE     = 5'd7;
  localparam logic [4:0] ST_BITS_BC      = 5'd8;
  localparam logic [4:0] ST_BITS_LEN     = 5'd9;
  localparam logic [4:0] ST_REGS_BC      = 5'd10;
  localparam logic [4:0] ST_REGS_ODD     = 5'd11;
  localparam logic [4:0] ST_REGS_LEN     = 5'd12;
  localparam logic [4:0] ST_WR1_LEN      = 5'd13;
  localparam logic [4:0] ST_WRN_LEN      = 5'd14;
  localparam logic [4:0] ST_DIAG_LEN     = 5'd15;
  localparam logic [4:0] ST_MEI_LEN      = 5'd16;
  localparam logic [4:0] ST_SENTINEL     = 5'd17;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } rx_beat_t;

  typedef struct packed {
    logic [4:0]  status;
    logic [15:0] txn_id;
    logic        update_id;
  } res_beat_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [15:0]      proto;
    logic [15:0]      length;
    logic [7:0]       func;
    logic [7:0]       second;
    logic             pattern;
  } frame_info_t;

endpackage

@@ hw/rtl/mbtc_judge.sv @@
// Frame verdict logic: turns a frame summary into one prioritized status code.
// Pure combinational. Depends on mbtc_pkg.
module mbtc_judge
  import mbtc_pkg::*;
(
  input  frame_info_t info,
  output logic [4:0]  status
);

  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] len_total;
  logic [CNT_W-1:0] bc_total;
  logic [4:0]       fc_rule;
  logic             has_fc;
  logic             has_b;

  assign n         = info.count;
  assign len_total = CNT_W'(info.length) + CNT_W'(HDR_BYTES);
  assign bc_total  = CNT_W'(info.second) + CNT_W'(8);
  assign has_fc    = n >= CNT_W'(HDR_BYTES + 1);
  assign has_b     = n >= CNT_W'(HDR_BYTES + 2);

  always_comb begin
    fc_rule = ST_OK;
    case (info.func)
      FC_RD_COILS, FC_RD_DISC: begin
        if (has_b) begin
          if (info.second == 8'd0 || info.second > BITS_BC_MAX) fc_rule = ST_BITS_BC;
          else if (n != bc_total) fc_rule = ST_BITS_LEN;
        end
      end
      FC_RD_HOLD, FC_RD_INPUT: begin
        if (has_b) begin
          if (info.second == 8'd0 || info.second > REGS_BC_MAX) fc_rule = ST_REGS_BC;
          else if (info.second[0]) fc_rule = ST_REGS_ODD;
          else if (n != bc_total) fc_rule = ST_REGS_LEN;
        end
      end
      FC_WR_COIL, FC_WR_REG: begin
        if (n != CNT_W'(11)) fc_rule = ST_WR1_LEN;
      end
      FC_WR_COILS, FC_WR_REGS: begin
        if (n != CNT_W'(11)) fc_rule = ST_WRN_LEN;
      end
      FC_DIAG: begin
        if (n != CNT_W'(11) && n != CNT_W'(13)) fc_rule = ST_DIAG_LEN;
      end
      FC_MEI: begin
        if (n < CNT_W'(9)) fc_rule = ST_MEI_LEN;
      end
      default: fc_rule = ST_OK;
    endcase
  end

  always_comb begin
    status = ST_OK;
    if (n < CNT_W'(HDR_BYTES)) begin
      status = ST_SHORT;
    end else if (info.proto != 16'd0) begin
      status = ST_PROTO;
    end else if (n != len_total) begin
      status = ST_LEN_MISMATCH;
    end else if (n > CNT_W'(MAX_FRAME)) begin
      status = ST_TOO_LONG;
    end else if (has_fc && info.func >= EXC_FLAG) begin
      if (has_b && (info.second == 8'd0 || info.second > EXC_CODE_MAX)) status = ST_EXC_CODE;
      else status = ST_EXCEPTION;
    end else if (has_fc && (info.func == 8'd0 || info.func > FC_MAX)) begin
      status = ST_FC_RANGE;
    end else if (has_fc && fc_rule != ST_OK) begin
      status = fc_rule;
    end else if (info.pattern) begin
      status = ST_SENTINEL;
    end
  end

endmodule

@@ hw/rtl/modbus_tcp_response_checker.sv @@
// Modbus TCP response checker top level: header capture, sentinel scan, output buffer.
// Depends on mbtc_pkg and mbtc_judge.
//
//   channel | valid     | stall     | payload  | beat
//   --------+-----------+-----------+----------+-------------------------------
//   rx      | rx_valid  | rx_stall  | rx_beat  | one frame byte + last mark
//   result  | res_valid | res_stall | res_beat | status, transaction id, flag
//
// One byte per cycle while rx_stall is low. A frame's result is registered when its
// last byte is taken; offered on the next cycle unless an unpopped result blocks it.
// Results leave through a two-entry buffer (output register plus skid); rx_stall
// rises only when both entries hold results.
// Reset clears frame state and both buffer entries.
module modbus_tcp_response_checker
  import mbtc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      rx_valid,
  output logic      rx_stall,
  input  rx_beat_t  rx_beat,
  output logic      res_valid,
  input  logic      res_stall,
  output res_beat_t res_beat
);

  logic [CNT_W-1:0] rx_count, rx_count_next;
  logic [15:0]      header_tid, header_tid_next;
  logic [15:0]      header_proto, header_proto_next;
  logic [15:0]      header_length, header_length_next;
  logic [7:0]       func_code, func_code_next;
  logic [7:0]       second_pdu_byte, second_pdu_byte_next;
  logic [23:0]      recent_bytes;
  logic             pattern_seen, pattern_next;

  logic             skid_valid;
  res_beat_t        skid_beat;
  logic             res_valid_next, skid_valid_next;
  res_beat_t        res_beat_next, skid_beat_next;

  logic             accept, produce, pop;
  logic [31:0]      window;
  frame_info_t      info;
  logic [4:0]       status;
  res_beat_t        new_beat;

  assign rx_stall = skid_valid;
  assign accept   = rx_valid && !skid_valid;
  assign produce  = accept && rx_beat.frame_end;
  assign pop      = res_valid && !res_stall;

  assign window = {recent_bytes, rx_beat.data_byte};

  always_comb begin
    header_tid_next      = header_tid;
    header_proto_next    = header_proto;
    header_length_next   = header_length;
    func_code_next       = func_code;
    second_pdu_byte_next = second_pdu_byte;
    case (rx_count)
      CNT_W'(0): header_tid_next[15:8]    = rx_beat.data_byte;
      CNT_W'(1): header_tid_next[7:0]     = rx_beat.data_byte;
      CNT_W'(2): header_proto_next[15:8]  = rx_beat.data_byte;
      CNT_W'(3): header_proto_next[7:0]   = rx_beat.data_byte;
      CNT_W'(4): header_length_next[15:8] = rx_beat.data_byte;
      CNT_W'(5): header_length_next[7:0]  = rx_beat.data_byte;
      CNT_W'(6): func_code_next           = rx_beat.data_byte;
      CNT_W'(7): second_pdu_byte_next     = rx_beat.data_byte;
      default: ;
    endcase
    pattern_next  = pattern_seen ||
                    (rx_count >= CNT_W'(3) && window == SENTINEL);
    rx_count_next = (rx_count == CNT_MAX) ? rx_count : rx_count + CNT_W'(1);
  end

  assign info.count   = rx_count_next;
  assign info.proto   = header_proto_next;
  assign info.length  = header_length_next;
  assign info.func    = func_code_next;
  assign info.second  = second_pdu_byte_next;
  assign info.pattern = pattern_next;

  mbtc_judge u_judge (
    .info   (info),
    .status (status)
  );

  assign new_beat.status    = status;
  assign new_beat.update_id = (status == ST_OK);
  assign new_beat.txn_id    = (status == ST_OK) ? header_tid_next : 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count        <= '0;
      header_tid      <= '0;
      header_proto    <= '0;
      header_length   <= '0;
      func_code       <= '0;
      second_pdu_byte <= '0;
      recent_bytes    <= '0;
      pattern_seen    <= 1'b0;
    end else if (accept) begin
      if (rx_beat.frame_end) begin
        rx_count        <= '0;
        header_tid      <= '0;
        header_proto    <= '0;
        header_length   <= '0;
        func_code       <= '0;
        second_pdu_byte <= '0;
        recent_bytes    <= '0;
        pattern_seen    <= 1'b0;
      end else begin
        rx_count        <= rx_count_next;
        header_tid      <= header_tid_next;
        header_proto    <= header_proto_next;
        header_length   <= header_length_next;
        func_code       <= func_code_next;
        second_pdu_byte <= second_pdu_byte_next;
        recent_bytes    <= window[23:0];
        pattern_seen    <= pattern_next;
      end
    end
  end

  // Output register plus skid entry.
  always_comb begin
    res_valid_next  = res_valid;
    res_beat_next   = res_beat;
    skid_valid_next = skid_valid;
    skid_beat_next  = skid_beat;
    if (pop || !res_valid) begin
      if (skid_valid) begin
        res_valid_next  = 1'b1;
        res_beat_next   = skid_beat;
        skid_valid_next = 1'b0;
      end else begin
        res_valid_next = produce;
        res_beat_next  = new_beat;
      end
    end else if (produce) begin
      skid_valid_next = 1'b1;
      skid_beat_next  = new_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      res_valid  <= res_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res_beat  <= res_beat_next;
    skid_beat <= skid_beat_next;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry full while output register empty");

  a_flag_matches_status: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_beat.update_id == (res_beat.status == ST_OK)))
    else $error("update flag disagrees with status");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    produce |=> (rx_count == '0 && !pattern_seen && recent_bytes == '0))
    else $error("frame state not cleared after last byte");

  a_mid_frame_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && !rx_beat.frame_end) |=> rx_count != '0)
    else $error("byte count lost on a mid-frame byte");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    (produce && !res_valid) |=> (res_valid && !skid_valid))
    else $error("result not placed in empty output register");

endmodule
